/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is held.
`define CEF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define CEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/cef_pkg.sv */
// ----------------------------------------------------------------------------
// cef_pkg
// Types and constants of the checksummed serial frame encoder.
// ----------------------------------------------------------------------------
package cef_pkg;

  localparam logic [7:0] SYNC_BYTE       = 8'h5A;
  localparam int         QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [15:0] element_value;
    logic [6:0]  element_count;
    logic [7:0]  function_code;
  } cef_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_frame;
  } cef_out_t;

  // One classified element as it waits between front and back.
  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  func;
    logic [7:0]  cnt_byte;
    logic        hdr;
    logic        word;
    logic        last;
  } cef_cmd_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_SYNC0,
    ST_SYNC1,
    ST_FUNC,
    ST_CNT,
    ST_HI,
    ST_LO,
    ST_SUM
  } cef_step_t;

endpackage

/* design/cef_front.sv */
// ----------------------------------------------------------------------------
// cef_front
// Accepts elements, tracks the open frame and builds byte commands.
// ----------------------------------------------------------------------------
module cef_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  cef_pkg::cef_in_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output cef_pkg::cef_cmd_t q_cmd
);

  logic       word_mode_r;
  logic [6:0] left_r, left_nxt;
  logic [6:0] left_cur;
  logic       opening;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign opening  = (left_r == 7'd0);
  assign left_cur = opening ? in_data.element_count : left_r;

  // An item that would open a frame with no elements is dropped.
  assign q_push = accept && (left_cur != 7'd0);

  always_comb begin
    q_cmd.value    = in_data.element_value;
    q_cmd.func     = in_data.function_code;
    q_cmd.cnt_byte = word_mode_r ? {in_data.element_count, 1'b0}
                                 : {1'b0, in_data.element_count};
    q_cmd.hdr      = opening;
    q_cmd.word     = word_mode_r;
    q_cmd.last     = (left_cur == 7'd1);
  end

  always_comb begin
    left_nxt = left_r;
    if (q_push) begin
      left_nxt = left_cur - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_mode_r <= 1'b1;
      left_r      <= 7'd0;
    end else begin
      left_r <= left_nxt;
      if (cfg_we) begin
        word_mode_r <= cfg_wdata;
      end
    end
  end

endmodule

/* design/cef_fifo.sv */
// ----------------------------------------------------------------------------
// cef_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module cef_fifo #(
  parameter int DEPTH = cef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cef_pkg::cef_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output cef_pkg::cef_cmd_t head_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cef_pkg::cef_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* design/cef_back.sv */
// ----------------------------------------------------------------------------
// cef_back
// Walks each queued command byte by byte, keeps the running sum and holds
// the output register.
// ----------------------------------------------------------------------------
module cef_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cef_pkg::cef_cmd_t head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output cef_pkg::cef_out_t out_data
);

  cef_pkg::cef_step_t step_r, step_nxt, cur_step;
  logic [7:0]         sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  cef_pkg::cef_out_t  out_data_r;
  logic [7:0]         byte_val;
  logic               final_step;
  logic               eof;
  logic               go;

  assign go  = head_valid && (!out_valid_r || out_ready);
  assign pop = go && final_step;

  // A fresh command starts at the header, or directly at its data bytes.
  always_comb begin
    if (step_r == cef_pkg::ST_START) begin
      if (head_cmd.hdr) begin
        cur_step = cef_pkg::ST_SYNC0;
      end else if (head_cmd.word) begin
        cur_step = cef_pkg::ST_HI;
      end else begin
        cur_step = cef_pkg::ST_LO;
      end
    end else begin
      cur_step = step_r;
    end
  end

  // Output decode of the current step.
  always_comb begin
    byte_val   = 8'h00;
    final_step = 1'b0;
    eof        = 1'b0;
    case (cur_step)
      cef_pkg::ST_SYNC0: byte_val = cef_pkg::SYNC_BYTE;
      cef_pkg::ST_SYNC1: byte_val = cef_pkg::SYNC_BYTE;
      cef_pkg::ST_FUNC:  byte_val = head_cmd.func;
      cef_pkg::ST_CNT:   byte_val = head_cmd.cnt_byte;
      cef_pkg::ST_HI:    byte_val = head_cmd.value[15:8];
      cef_pkg::ST_LO: begin
        byte_val   = head_cmd.value[7:0];
        final_step = !head_cmd.last;
      end
      cef_pkg::ST_SUM: begin
        byte_val   = sum_r;
        final_step = 1'b1;
        eof        = 1'b1;
      end
      default: byte_val = 8'h00;
    endcase
  end

  // Next step.
  always_comb begin
    step_nxt = step_r;
    if (go) begin
      if (final_step) begin
        step_nxt = cef_pkg::ST_START;
      end else begin
        case (cur_step)
          cef_pkg::ST_SYNC0: step_nxt = cef_pkg::ST_SYNC1;
          cef_pkg::ST_SYNC1: step_nxt = cef_pkg::ST_FUNC;
          cef_pkg::ST_FUNC:  step_nxt = cef_pkg::ST_CNT;
          cef_pkg::ST_CNT:   step_nxt = head_cmd.word ? cef_pkg::ST_HI : cef_pkg::ST_LO;
          cef_pkg::ST_HI:    step_nxt = cef_pkg::ST_LO;
          cef_pkg::ST_LO:    step_nxt = cef_pkg::ST_SUM;
          default:           step_nxt = cef_pkg::ST_START;
        endcase
      end
    end
  end

  // The first sync byte restarts the sum; the checksum byte is not summed.
  always_comb begin
    sum_nxt = sum_r;
    if (go) begin
      if (eof) begin
        sum_nxt = 8'h00;
      end else begin
        sum_nxt = ((cur_step == cef_pkg::ST_SYNC0) ? 8'h00 : sum_r) + byte_val;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= cef_pkg::ST_START;
      sum_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r.out_byte     <= byte_val;
      out_data_r.last_of_run  <= final_step;
      out_data_r.end_of_frame <= eof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/checksummed_serial_frame_encoder_top.sv */
// ----------------------------------------------------------------------------
// checksummed_serial_frame_encoder_top
// Frame encoder: header, data bytes and additive checksum from elements.
// ----------------------------------------------------------------------------
//   channel  ports                         role
//   in       in_valid/in_ready/in_data     data elements, header fields
//   out      out_valid/out_ready/out_data  frame bytes, one per item
//   cfg      cfg_we/cfg_wdata              word_mode register
//
// The back emits one byte per cycle unless stalled; an element gives 1 byte
// in byte mode or 2 in word mode, plus 4 header bytes and 1 checksum byte per frame.
// The front accepts while the command queue has room; out_ready stalls the
// back, and once the queue fills, in_ready drops until the back pops.
// Reset is synchronous: frame closed, sum cleared, word_mode set.
// Items that would open a frame with a zero count are dropped.
// ----------------------------------------------------------------------------
module checksummed_serial_frame_encoder_top #(
  parameter int QUEUE_DEPTH = cef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  cef_pkg::cef_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cef_pkg::cef_out_t out_data
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_head_valid;
  cef_pkg::cef_cmd_t q_cmd;
  cef_pkg::cef_cmd_t q_head;

  cef_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  cef_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_cmd  (q_head)
  );

  cef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_head_valid),
    .head_cmd  (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/cef_checker.sv */
// ----------------------------------------------------------------------------
// cef_checker
// Port-level checks of the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cef_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input cef_pkg::cef_out_t out_data
);

  logic out_stall;
  logic out_take;
  logic out_eof;

  assign out_stall = out_valid && !out_ready;
  assign out_take  = out_valid && out_ready;
  assign out_eof   = out_valid && out_data.end_of_frame;

  // A stalled result holds its byte and flags.
  `CEF_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_data), "stalled item changed")

  // The checksum byte always closes the run of its item.
  `CEF_ASSERT(a_eof_last, clk, rst_n, out_eof |-> out_data.last_of_run, "checksum without last_of_run")

  // A new frame starts with a sync byte, so two checksums never follow directly.
  `CEF_ASSERT(a_eof_gap, clk, rst_n, out_take && out_eof |=> !out_eof, "two checksum bytes in a row")

  // The output register is empty right after reset.
  `CEF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind checksummed_serial_frame_encoder_top cef_checker u_cef_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

/* bench/checksummed_serial_frame_encoder_top_test.sv */
// ----------------------------------------------------------------------------
// checksummed_serial_frame_encoder_top_test
// Drives data elements into the frame encoder and checks every frame byte
// against a predictor of the header, data bytes and additive checksum, with
// random idling on both channels and word_mode changes inside open frames.
// ----------------------------------------------------------------------------
module checksummed_serial_frame_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int TARGET_ITEMS  = 210;

  // Predicts the frame bytes that each accepted element causes.
  class frame_scoreboard;
    bit                frame_mode_dummy;
    bit                word_mode;
    logic [7:0]        frame_sum;
    logic [6:0]        elems_left;
    cef_pkg::cef_out_t frame_bytes_q[$];
    int                errors;

    function new();
      frame_mode_dummy = 1'b0;
      word_mode        = 1'b1;
      frame_sum        = '0;
      elems_left       = '0;
      errors           = 0;
    endfunction

    function bit frame_open();
      return elems_left != 0;
    endfunction

    function int pending();
      return frame_bytes_q.size();
    endfunction

    function void push_byte(logic [7:0] b, bit eof);
      cef_pkg::cef_out_t r;
      r.out_byte     = b;
      r.last_of_run  = 1'b0;
      r.end_of_frame = eof;
      frame_bytes_q.push_back(r);
      if (!eof) frame_sum = frame_sum + b;
    endfunction

    function void note_input(cef_pkg::cef_in_t it);
      if (elems_left == 0) begin
        // An element that would open an empty frame is dropped.
        if (it.element_count == 0) return;
        frame_sum = '0;
        push_byte(cef_pkg::SYNC_BYTE, 1'b0);
        push_byte(cef_pkg::SYNC_BYTE, 1'b0);
        push_byte(it.function_code, 1'b0);
        push_byte(word_mode ? {it.element_count, 1'b0} : {1'b0, it.element_count}, 1'b0);
        elems_left = it.element_count;
      end
      if (word_mode) push_byte(it.element_value[15:8], 1'b0);
      push_byte(it.element_value[7:0], 1'b0);
      elems_left = elems_left - 7'd1;
      if (elems_left == 0) begin
        push_byte(frame_sum, 1'b1);
        frame_sum = '0;
      end
      frame_bytes_q[frame_bytes_q.size() - 1].last_of_run = 1'b1;
    endfunction

    function void check_result(cef_pkg::cef_out_t got);
      cef_pkg::cef_out_t want;
      if (frame_bytes_q.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = frame_bytes_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %b actual %b", $time,
                 want.last_of_run, got.last_of_run);
        errors++;
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        $display("%0t: end_of_frame expected %b actual %b", $time,
                 want.end_of_frame, got.end_of_frame);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cef_pkg::cef_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cef_pkg::cef_out_t out_data;

  bit burst    = 1'b0;
  bit hold_req = 1'b0;

  frame_scoreboard sb = new();

  checksummed_serial_frame_encoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Inputs are noted before results are checked within the same edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function int pick_gap();
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high, so the caller either sends again or idles.
  task automatic drive_item(logic [15:0] value, logic [6:0] count, logic [7:0] func);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{element_value: value, element_count: count, function_code: func};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Mode is changed only once every expected byte has left the block.
  task automatic drain_and_set_mode(bit mode);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we       <= 1'b0;
    sb.word_mode = mode;
  endtask

  initial begin : receiver
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int         items_done;
    int         phase;
    int         phase_end;
    int         pick;
    bit         big_done;
    logic [6:0] count;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Word mode out of reset; an empty frame is dropped.
    drive_item(16'h1111, 7'd0, 8'hAA);
    drive_item(16'hFFFF, 7'd1, 8'hFF);
    drive_item(16'h0000, 7'd1, 8'h00);
    // Count and function are ignored after the first element.
    drive_item(16'h1234, 7'd2, 8'h3C);
    drive_item(16'hABCD, 7'd0, 8'h55);
    // Word mode to byte mode inside an open frame.
    drive_item(16'h8001, 7'd3, 8'h81);
    drain_and_set_mode(1'b0);
    drive_item(16'h7F7F, 7'd127, 8'hFF);
    drive_item(16'h00FF, 7'd5, 8'h0F);
    drive_item(16'hFFFF, 7'd0, 8'h12);
    drive_item(16'hFFFF, 7'd1, 8'hFF);
    drive_item(16'h0000, 7'd1, 8'h00);
    // Byte mode to word mode inside an open frame.
    drive_item(16'h5555, 7'd2, 8'hC3);
    drain_and_set_mode(1'b1);
    drive_item(16'hAAAA, 7'd9, 8'h99);
    items_done = 13;

    phase    = 0;
    big_done = 1'b0;
    while (items_done < TARGET_ITEMS) begin
      drain_and_set_mode((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
      burst = (phase == 1) || ($urandom_range(0, 3) == 0);
      if (phase == 1) hold_req = 1'b1;
      phase_end = items_done + $urandom_range(15, 30);
      while (items_done < phase_end && items_done < TARGET_ITEMS) begin
        if (!sb.frame_open()) begin
          pick = $urandom_range(0, 9);
          if (phase == 3 && !big_done) begin
            count    = 7'd127;
            big_done = 1'b1;
          end else if (pick == 0) count = 7'd0;
          else if (pick == 1) count = 7'($urandom_range(7, 20));
          else count = 7'($urandom_range(1, 6));
          if (count != 0) items_done++;
        end else begin
          count = 7'($urandom);
          items_done++;
        end
        drive_item(16'($urandom), count, 8'($urandom));
      end
      phase++;
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
